// ===== rtl/fdmd_pkg.sv =====
// ----------------------------------------------------------------------------
// fdmd_pkg
// Shared types and constants of the frame difference motion detector:
// configuration register codes, the configuration bundle and the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

package fdmd_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 19;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERCENT_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXELS_PER_FRAME  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STATS_ENABLE      = 2'd3;

  // register reset values
  localparam logic [7:0]  DELTA_RESET   = 8'd16;
  localparam logic [14:0] PERCENT_RESET = 15'd256;
  localparam logic [18:0] PIXELS_RESET  = 19'd262144;

  // 100 percent in q8
  localparam int unsigned MOTION_SCALE = 25600;

  // statistics limits
  localparam logic [8:0]  MIN_RESET = 9'd256;
  localparam logic [25:0] SUM_MAX   = 26'h3FF_FFFF;

  // configuration bundle
  typedef struct packed {
    logic [7:0]  delta_threshold;
    logic [14:0] percent_threshold_q8;
    logic [18:0] pixels_per_frame;
    logic        stats_enable;
  } cfg_t;

  // one result beat
  typedef struct packed {
    logic        motion_flag;
    logic [18:0] changed_count;
    logic [8:0]  min_difference;
    logic [7:0]  max_difference;
    logic [25:0] difference_sum;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/fdmd_fifo.sv =====
// ----------------------------------------------------------------------------
// fdmd_fifo
// Small synchronous queue with count, used between front and back and for
// the finished results.
// ----------------------------------------------------------------------------
`default_nettype none

module fdmd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fdmd_front.sv =====
// ----------------------------------------------------------------------------
// fdmd_front
// Accepts pixels, tracks the raster position and the reference frame status,
// and tags each pixel with its reference status, store address and end-of-frame mark.
// ----------------------------------------------------------------------------
`default_nettype none

module fdmd_front #(
  parameter  int unsigned MAX_PIXELS = 262144,
  localparam int unsigned IDX_W      = $clog2(MAX_PIXELS),
  localparam int unsigned CNT_W      = (IDX_W + 1 > 19) ? IDX_W + 1 : 19
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [7:0]                    pixel_i,
  input  wire logic [CNT_W-1:0]              frame_size_i,
  output logic [IDX_W+9:0]                   entry_o
);

  logic [IDX_W-1:0] pixel_index_q, pixel_index_d;
  logic             have_ref_q, have_ref_d;
  logic [CNT_W-1:0] index_next;
  logic             last;

  // end of frame when the next position reaches the frame size
  assign index_next = CNT_W'(pixel_index_q) + CNT_W'(1);
  assign last       = (index_next >= frame_size_i);

  // tagged pixel: reference, last, address, value
  assign entry_o = {have_ref_q, last, pixel_index_q, pixel_i};

  always_comb begin
    pixel_index_d = pixel_index_q;
    have_ref_d    = have_ref_q;
    if (accept_i) begin
      if (last) begin
        pixel_index_d = '0;
        have_ref_d    = 1'b1;
      end else begin
        pixel_index_d = index_next[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_index_q <= '0;
      have_ref_q    <= 1'b0;
    end else begin
      pixel_index_q <= pixel_index_d;
      have_ref_q    <= have_ref_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fdmd_back.sv =====
// ----------------------------------------------------------------------------
// fdmd_back
// Frame store read-modify-write, difference statistics and the motion test.
// Three lockstep stages that hold while the result queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module fdmd_back #(
  parameter  int unsigned MAX_PIXELS = 262144,
  localparam int unsigned IDX_W      = $clog2(MAX_PIXELS),
  localparam int unsigned CNT_W      = (IDX_W + 1 > 19) ? IDX_W + 1 : 19
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire fdmd_pkg::cfg_t       cfg_i,
  input  wire logic [CNT_W-1:0]     frame_size_i,
  input  wire logic                 q_empty_i,
  input  wire logic [IDX_W+9:0]     q_entry_i,
  output logic                      q_pop_o,
  input  wire logic                 res_full_i,
  output logic                      res_push_o,
  output fdmd_pkg::result_t         res_o
);

  localparam int unsigned PROD_W = CNT_W + 15;

  // queue entry fields
  logic [7:0]       in_pix;
  logic [IDX_W-1:0] in_idx;
  logic             in_last, in_ref;
  assign {in_ref, in_last, in_idx, in_pix} = q_entry_i;

  logic en, issue;
  assign en      = !res_full_i;
  assign issue   = en && !q_empty_i;
  assign q_pop_o = issue;

  // stage a: frame store, read old value and write new in one access
  logic [7:0] store_q [MAX_PIXELS];
  logic [7:0] old_q;
  logic [7:0] pix_a_q;
  logic       last_a_q, ref_a_q;
  logic       va_q;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      store_q[in_idx] <= in_pix;
      old_q           <= store_q[in_idx];
      pix_a_q         <= in_pix;
      last_a_q        <= in_last;
      ref_a_q         <= in_ref;
    end
  end

  // stage b: difference and accumulators
  logic [CNT_W-1:0] changed_q, changed_d, changed_nxt;
  logic [8:0]       min_q, min_d, min_nxt;
  logic [7:0]       max_q, max_d, max_nxt;
  logic [25:0]      sum_q, sum_d, sum_nxt;
  logic [26:0]      sum_wide;
  logic [7:0]       diff;
  logic             upd, capture;

  assign upd     = en && va_q;
  assign capture = upd && last_a_q && ref_a_q;
  assign diff    = (old_q > pix_a_q) ? (old_q - pix_a_q) : (pix_a_q - old_q);
  assign sum_wide = {1'b0, sum_q} + 27'(diff);

  always_comb begin
    changed_nxt = changed_q;
    min_nxt     = min_q;
    max_nxt     = max_q;
    sum_nxt     = sum_q;
    if (ref_a_q) begin
      if (diff >= cfg_i.delta_threshold) begin
        changed_nxt = changed_q + CNT_W'(1);
      end
      if (cfg_i.stats_enable) begin
        sum_nxt = sum_wide[26] ? fdmd_pkg::SUM_MAX : sum_wide[25:0];
        if (9'(diff) < min_q) begin
          min_nxt = 9'(diff);
        end
        if (diff > max_q) begin
          max_nxt = diff;
        end
      end
    end
  end

  // accumulators restart at every frame end
  always_comb begin
    changed_d = changed_q;
    min_d     = min_q;
    max_d     = max_q;
    sum_d     = sum_q;
    if (upd) begin
      if (last_a_q) begin
        changed_d = '0;
        min_d     = fdmd_pkg::MIN_RESET;
        max_d     = '0;
        sum_d     = '0;
      end else begin
        changed_d = changed_nxt;
        min_d     = min_nxt;
        max_d     = max_nxt;
        sum_d     = sum_nxt;
      end
    end
  end

  // stage c: products of the motion test and the frame totals
  logic [PROD_W-1:0] lhs_q, rhs_q;
  logic              vc_q;
  logic [18:0]       cnt_c_q;
  logic [8:0]        min_c_q;
  logic [7:0]        max_c_q;
  logic [25:0]       sum_c_q;

  always_ff @(posedge clk_i) begin
    if (capture) begin
      lhs_q   <= PROD_W'(changed_nxt) * PROD_W'(fdmd_pkg::MOTION_SCALE);
      rhs_q   <= PROD_W'(cfg_i.percent_threshold_q8) * PROD_W'(frame_size_i);
      cnt_c_q <= changed_nxt[18:0];
      min_c_q <= min_nxt;
      max_c_q <= max_nxt;
      sum_c_q <= sum_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q      <= 1'b0;
      vc_q      <= 1'b0;
      changed_q <= '0;
      min_q     <= fdmd_pkg::MIN_RESET;
      max_q     <= '0;
      sum_q     <= '0;
    end else begin
      if (en) begin
        va_q <= issue;
        vc_q <= capture;
      end
      changed_q <= changed_d;
      min_q     <= min_d;
      max_q     <= max_d;
      sum_q     <= sum_d;
    end
  end

  // result beat
  assign res_push_o           = en && vc_q;
  assign res_o.motion_flag    = (lhs_q >= rhs_q);
  assign res_o.changed_count  = cnt_c_q;
  assign res_o.min_difference = min_c_q;
  assign res_o.max_difference = max_c_q;
  assign res_o.difference_sum = sum_c_q;

endmodule

`default_nettype wire

// ===== rtl/frame_difference_motion_detect.sv =====
// ----------------------------------------------------------------------------
// frame_difference_motion_detect
// Frame differencing motion detector: compares each pixel with the same
// position of the previous frame and reports per-frame change statistics.
//
//   channel  direction  handshake            beat
//   pixel    in         push / full          pixel_value_i
//   result   out        empty / pop          motion_flag_o .. difference_sum_o
//   config   in         cfg_valid_i / ready  cfg_index_i, cfg_data_i
//
// One pixel per clock sustained while the result queue has room; the frame store is a single-port memory
// accessed once per pixel, reading the old value and writing the new one.
// A result leaves the back end from the stage c registers, after its last pixel passes the pixel queue and stage a.
// Reset clears position, reference status and accumulators; store contents
// stay undefined until the first frame writes them.
// A full result queue stalls the back end; a four-entry queue lets the front
// keep accepting pixels until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_difference_motion_detect #(
  parameter int unsigned MAX_PIXELS = 262144
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // pixel channel
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [7:0]                      pixel_value_i,
  // result channel
  output logic                                 empty,
  input  wire logic                            pop,
  output logic                                 motion_flag_o,
  output logic [18:0]                          changed_count_o,
  output logic [8:0]                           min_difference_o,
  output logic [7:0]                           max_difference_o,
  output logic [25:0]                          difference_sum_o,
  // configuration channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [fdmd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [fdmd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(MAX_PIXELS);
  localparam int unsigned CNT_W = (IDX_W + 1 > 19) ? IDX_W + 1 : 19;
  localparam int unsigned ENT_W = IDX_W + 10;

  // configuration registers
  fdmd_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delta_threshold      <= fdmd_pkg::DELTA_RESET;
      cfg_q.percent_threshold_q8 <= fdmd_pkg::PERCENT_RESET;
      cfg_q.pixels_per_frame     <= fdmd_pkg::PIXELS_RESET;
      cfg_q.stats_enable         <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        fdmd_pkg::REG_DELTA_THRESHOLD:   cfg_q.delta_threshold      <= cfg_data_i[7:0];
        fdmd_pkg::REG_PERCENT_THRESHOLD: cfg_q.percent_threshold_q8 <= cfg_data_i[14:0];
        fdmd_pkg::REG_PIXELS_PER_FRAME:  cfg_q.pixels_per_frame     <= cfg_data_i;
        fdmd_pkg::REG_STATS_ENABLE:      cfg_q.stats_enable         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective frame size, clamped to one .. store depth
  logic [CNT_W-1:0] ppf_ext, frame_size;
  assign ppf_ext = CNT_W'(cfg_q.pixels_per_frame);

  always_comb begin
    priority if (ppf_ext == '0) begin
      frame_size = CNT_W'(1);
    end else if (ppf_ext > CNT_W'(MAX_PIXELS)) begin
      frame_size = CNT_W'(MAX_PIXELS);
    end else begin
      frame_size = ppf_ext;
    end
  end

  // front: position tracking
  logic             in_accept;
  logic [ENT_W-1:0] front_entry, q_entry;
  logic             q_empty, q_pop;

  assign in_accept = push && !full;

  fdmd_front #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .pixel_i      (pixel_value_i),
    .frame_size_i (frame_size),
    .entry_o      (front_entry)
  );

  // queue between front and back
  fdmd_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (4)
  ) u_pix_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .wdata_i (front_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .rdata_o (q_entry),
    .empty_o (q_empty)
  );

  // back: store access, statistics, motion test
  logic              res_full, res_push;
  fdmd_pkg::result_t res_in, res_out;

  fdmd_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .frame_size_i (frame_size),
    .q_empty_i    (q_empty),
    .q_entry_i    (q_entry),
    .q_pop_o      (q_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  // result queue
  fdmd_fifo #(
    .WIDTH ($bits(fdmd_pkg::result_t)),
    .DEPTH (4)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign motion_flag_o    = res_out.motion_flag;
  assign changed_count_o  = res_out.changed_count;
  assign min_difference_o = res_out.min_difference;
  assign max_difference_o = res_out.max_difference;
  assign difference_sum_o = res_out.difference_sum;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame difference motion detector. A fill
// frame first writes the part of the frame store that later frames use.
// A table of short directed steps then hits the register extremes,
// frame-size clamping and mid-frame changes of frame size and statistics.
// Random frames follow under changing register settings and handshake
// idling. A shadow model of the store and the per-frame accumulators
// predicts the result beats that the table does not give by hand, and each beat is compared field by field.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_CAP       = 262144;
  localparam longint unsigned FULL_Q8     = 25600;
  localparam logic [26:0] SUM_CEIL        = 27'h3FF_FFFF;
  localparam int unsigned REST_CYCLES     = 12;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned NUM_ROWS        = 32;
  localparam int unsigned PHASES          = 4;
  localparam int unsigned BLOCKS          = 7;
  localparam int unsigned BLOCK_PIXELS    = 50;

  // directed step: a register write or a run of equal pixels
  typedef enum logic {STEP_CFG, STEP_FEED} step_kind_e;

  typedef struct packed {
    step_kind_e        kind;
    logic [1:0]        reg_idx;
    logic [18:0]       value;     // register data, or pixel count of a feed
    logic [7:0]        pix;
    logic              typed;     // frame result given by hand
    fdmd_pkg::result_t want;
  } plan_row_t;

  localparam plan_row_t PLAN [NUM_ROWS] = '{
    // fill frame covering every position that later frames reach
    '{STEP_CFG,  fdmd_pkg::REG_PIXELS_PER_FRAME,  19'd64,      8'd0,   1'b0, '0},
    '{STEP_FEED, '0,                              19'd64,      8'd0,   1'b0, '0},
    // one-pixel frames, frame size zero clamps to one
    '{STEP_CFG,  fdmd_pkg::REG_STATS_ENABLE,      19'd1,       8'd0,   1'b0, '0},
    '{STEP_CFG,  fdmd_pkg::REG_PIXELS_PER_FRAME,  19'd0,       8'd0,   1'b0, '0},
    '{STEP_FEED, '0,                              19'd1,       8'd0,   1'b1,
      '{1'b0, 19'd0, 9'd0, 8'd0, 26'd0}},
    '{STEP_FEED, '0,                              19'd1,       8'd255, 1'b1,
      '{1'b1, 19'd1, 9'd255, 8'd255, 26'd255}},
    '{STEP_FEED, '0,                              19'd1,       8'd0,   1'b1,
      '{1'b1, 19'd1, 9'd255, 8'd255, 26'd255}},
    '{STEP_CFG,  fdmd_pkg::REG_DELTA_THRESHOLD,   19'd0,       8'd0,   1'b0, '0},
    '{STEP_FEED, '0,                              19'd1,       8'd0,   1'b1,
      '{1'b1, 19'd1, 9'd0, 8'd0, 26'd0}},
    '{STEP_CFG,  fdmd_pkg::REG_DELTA_THRESHOLD,   19'd255,     8'd0,   1'b0, '0},
    '{STEP_FEED, '0,                              19'd1,       8'd255, 1'b1,
      '{1'b1, 19'd1, 9'd255, 8'd255, 26'd255}},
    '{STEP_FEED, '0,                              19'd1,       8'd254, 1'b1,
      '{1'b0, 19'd0, 9'd1, 8'd1, 26'd1}},
    // statistics off report the idle values
    '{STEP_CFG,  fdmd_pkg::REG_STATS_ENABLE,      19'd0,       8'd0,   1'b0, '0},
    '{STEP_FEED, '0,                              19'd1,       8'd254, 1'b1,
      '{1'b0, 19'd0, 9'd256, 8'd0, 26'd0}},
    // percent threshold extremes
    '{STEP_CFG,  fdmd_pkg::REG_PERCENT_THRESHOLD, 19'd0,       8'd0,   1'b0, '0},
    '{STEP_FEED, '0,                              19'd1,       8'd254, 1'b1,
      '{1'b1, 19'd0, 9'd256, 8'd0, 26'd0}},
    '{STEP_CFG,  fdmd_pkg::REG_PERCENT_THRESHOLD, 19'h7FFF,    8'd0,   1'b0, '0},
    '{STEP_CFG,  fdmd_pkg::REG_DELTA_THRESHOLD,   19'd1,       8'd0,   1'b0, '0},
    '{STEP_FEED, '0,                              19'd1,       8'd0,   1'b1,
      '{1'b0, 19'd1, 9'd256, 8'd0, 26'd0}},
    '{STEP_CFG,  fdmd_pkg::REG_PERCENT_THRESHOLD, 19'd25600,   8'd0,   1'b0, '0},
    '{STEP_FEED, '0,                              19'd1,       8'd255, 1'b1,
      '{1'b1, 19'd1, 9'd256, 8'd0, 26'd0}},
    // statistics switched off halfway through a frame
    '{STEP_CFG,  fdmd_pkg::REG_PIXELS_PER_FRAME,  19'd6,       8'd0,   1'b0, '0},
    '{STEP_CFG,  fdmd_pkg::REG_STATS_ENABLE,      19'd1,       8'd0,   1'b0, '0},
    '{STEP_FEED, '0,                              19'd3,       8'd100, 1'b0, '0},
    '{STEP_CFG,  fdmd_pkg::REG_STATS_ENABLE,      19'd0,       8'd0,   1'b0, '0},
    '{STEP_FEED, '0,                              19'd3,       8'd7,   1'b0, '0},
    // frame size shrinks below the current position
    '{STEP_FEED, '0,                              19'd4,       8'd9,   1'b0, '0},
    '{STEP_CFG,  fdmd_pkg::REG_PIXELS_PER_FRAME,  19'd2,       8'd0,   1'b0, '0},
    '{STEP_FEED, '0,                              19'd1,       8'd3,   1'b0, '0},
    // frame size grows mid-frame
    '{STEP_FEED, '0,                              19'd1,       8'd1,   1'b0, '0},
    '{STEP_CFG,  fdmd_pkg::REG_PIXELS_PER_FRAME,  19'd5,       8'd0,   1'b0, '0},
    '{STEP_FEED, '0,                              19'd4,       8'd200, 1'b0, '0}
  };

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // block ports
  logic                            push;
  logic                            full;
  logic [7:0]                      pixel_value;
  logic                            empty;
  logic                            pop = 1'b0;
  logic                            motion_flag;
  logic [18:0]                     changed_count;
  logic [8:0]                      min_difference;
  logic [7:0]                      max_difference;
  logic [25:0]                     difference_sum;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [fdmd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fdmd_pkg::CFG_DATA_W-1:0] cfg_data;

  frame_difference_motion_detect dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .pixel_value_i    (pixel_value),
    .empty            (empty),
    .pop              (pop),
    .motion_flag_o    (motion_flag),
    .changed_count_o  (changed_count),
    .min_difference_o (min_difference),
    .max_difference_o (max_difference),
    .difference_sum_o (difference_sum),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  // shadow of the frame store, accumulators and registers
  logic [7:0]     prior_frame [FRAME_CAP];
  bit             ref_valid     = 1'b0;
  int unsigned    pix_pos       = 0;
  int unsigned    changed_tally = 0;
  logic [8:0]     min_seen      = 9'd256;
  logic [7:0]     max_seen      = 8'd0;
  logic [26:0]    diff_total    = '0;
  fdmd_pkg::cfg_t regs          = '{8'd16, 15'd256, 19'd262144, 1'b0};

  // frame reports still to come out of the block, oldest first
  fdmd_pkg::result_t pending_reports [$];

  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;
  int unsigned hold_left      = 0;
  bit          hold_req       = 1'b0;
  int unsigned quiet_cycles   = 0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string field, input logic [25:0] got,
                               input logic [25:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
  endtask

  // one pixel through the shadow; closes is set when a frame report is due
  task automatic advance_motion_model(input logic [7:0] pix, output bit closes,
                                      output fdmd_pkg::result_t rpt);
    int unsigned     frame_len;
    logic [7:0]      old_pix;
    logic [7:0]      diff;
    longint unsigned lhs;
    longint unsigned rhs;
    frame_len = 32'(regs.pixels_per_frame);
    if (frame_len < 1) frame_len = 1;
    if (frame_len > FRAME_CAP) frame_len = FRAME_CAP;
    old_pix = prior_frame[pix_pos[17:0]];
    prior_frame[pix_pos[17:0]] = pix;
    closes = 1'b0;
    rpt = '0;
    if (ref_valid) begin
      diff = (old_pix > pix) ? old_pix - pix : pix - old_pix;
      if (regs.stats_enable) begin
        diff_total = diff_total + 27'(diff);
        if (diff_total > SUM_CEIL) diff_total = SUM_CEIL;
        if (9'(diff) < min_seen) min_seen = 9'(diff);
        if (diff > max_seen) max_seen = diff;
      end
      if (diff >= regs.delta_threshold) changed_tally++;
    end
    pix_pos++;
    // frame ends once the position reaches the current frame size
    if (pix_pos >= frame_len) begin
      if (ref_valid) begin
        lhs = longint'(changed_tally) * FULL_Q8;
        rhs = longint'(regs.percent_threshold_q8) * frame_len;
        rpt.motion_flag    = (lhs >= rhs);
        rpt.changed_count  = changed_tally[18:0];
        rpt.min_difference = min_seen;
        rpt.max_difference = max_seen;
        rpt.difference_sum = diff_total[25:0];
        closes = 1'b1;
      end
      ref_valid     = 1'b1;
      pix_pos       = 0;
      changed_tally = 0;
      min_seen      = 9'd256;
      max_seen      = 8'd0;
      diff_total    = '0;
    end
  endtask

  // offer one pixel beat, with random idle cycles ahead of it
  task automatic send_pixel(input logic [7:0] pix, input bit use_typed,
                            input fdmd_pkg::result_t typed_rpt);
    bit                closes;
    fdmd_pkg::result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    pixel_value <= pix;
    do @(posedge clk_i); while (full !== 1'b0);
    advance_motion_model(pix, closes, predicted);
    if (closes) pending_reports.push_back(use_typed ? typed_rpt : predicted);
  endtask

  // stop offering, wait for every report, then let the pipeline empty
  task automatic drain_and_rest();
    push      <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (REST_CYCLES) @(posedge clk_i);
  endtask

  // register write beat; valid stays up for the caller to lower
  task automatic write_reg(input logic [fdmd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fdmd_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (cfg_ready !== 1'b1);
    case (idx)
      fdmd_pkg::REG_DELTA_THRESHOLD:   regs.delta_threshold      = val[7:0];
      fdmd_pkg::REG_PERCENT_THRESHOLD: regs.percent_threshold_q8 = val[14:0];
      fdmd_pkg::REG_PIXELS_PER_FRAME:  regs.pixels_per_frame     = val[18:0];
      fdmd_pkg::REG_STATS_ENABLE:      regs.stats_enable         = val[0];
      default: ;
    endcase
  endtask

  // result side: check accepted beats, then pick the next pop
  always @(posedge clk_i) begin : result_side
    fdmd_pkg::result_t want;
    if (pop && !empty) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("result beat with no frame report pending");
      end else begin
        want = pending_reports.pop_front();
        compare_field("motion_flag", 26'(motion_flag), 26'(want.motion_flag));
        compare_field("changed_count", 26'(changed_count), 26'(want.changed_count));
        compare_field("min_difference", 26'(min_difference), 26'(want.min_difference));
        compare_field("max_difference", 26'(max_difference), 26'(want.max_difference));
        compare_field("difference_sum", difference_sum, want.difference_sum);
      end
    end
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      pop       <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else begin
      pop <= rst_ni && ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles in which no beat moves on any channel
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] watchdog: no beat for %0d cycles", $time, quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int unsigned r;
    int unsigned k;
    int unsigned phase;
    int unsigned blk;
    int unsigned writes;
    int          gap;
    logic [7:0]  pix;
    logic [7:0]  old_pix;
    logic [1:0]  idx;
    logic [18:0] val;

    rst_ni      <= 1'b0;
    push        <= 1'b0;
    pixel_value <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed steps
    for (r = 0; r < NUM_ROWS; r++) begin
      if (PLAN[r].kind == STEP_CFG) begin
        drain_and_rest();
        write_reg(PLAN[r].reg_idx, PLAN[r].value);
      end else begin
        cfg_valid <= 1'b0;
        for (k = 0; k < 32'(PLAN[r].value); k++)
          send_pixel(PLAN[r].pix, PLAN[r].typed, PLAN[r].want);
      end
    end

    // random frames under changing settings and idling
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      for (blk = 0; blk < BLOCKS; blk++) begin
        drain_and_rest();
        if (phase == 0 && blk == 0) begin
          // one-pixel frames against a stalled receiver fill the block
          write_reg(fdmd_pkg::REG_PIXELS_PER_FRAME, 19'd1);
          cfg_valid <= 1'b0;
          @(negedge clk_i);
          hold_req = 1'b1;
          @(posedge clk_i);
          hold_req <= 1'b0;
        end else begin
          writes = $urandom_range(1, 4);
          repeat (writes) begin
            idx = 2'($urandom_range(3));
            val = 19'($urandom);
            case (idx)
              fdmd_pkg::REG_DELTA_THRESHOLD:
                if ($urandom_range(3) == 0) val[7:0] = $urandom_range(1) ? 8'hFF : 8'h00;
              fdmd_pkg::REG_PERCENT_THRESHOLD:
                if ($urandom_range(4) != 0) val[14:0] = 15'($urandom_range(25600));
              fdmd_pkg::REG_PIXELS_PER_FRAME:
                case ($urandom_range(9))
                  0: val = '0;
                  1: val = 19'($urandom_range(17, 64));
                  default: val = 19'($urandom_range(1, 16));
                endcase
              default: ;
            endcase
            write_reg(idx, val);
          end
          cfg_valid <= 1'b0;
        end
        for (k = 0; k < BLOCK_PIXELS; k++) begin
          old_pix = prior_frame[pix_pos[17:0]];
          case ($urandom_range(3))
            0: pix = 8'($urandom);
            1: pix = old_pix;
            default: begin
              // difference right at the delta threshold, one either side
              gap = int'(regs.delta_threshold) + int'($urandom_range(2)) - 1;
              if (gap < 0) gap = 0;
              if (gap > 255) gap = 255;
              if (int'(old_pix) + gap <= 255 && (int'(old_pix) < gap || $urandom_range(1)))
                pix = old_pix + gap[7:0];
              else if (int'(old_pix) >= gap)
                pix = old_pix - gap[7:0];
              else
                pix = 8'($urandom);
            end
          endcase
          send_pixel(pix, 1'b0, '0);
        end
      end
    end

    drain_and_rest();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fdmd_pkg.sv
rtl/fdmd_fifo.sv
rtl/fdmd_front.sv
rtl/fdmd_back.sv
rtl/frame_difference_motion_detect.sv
bench/tb_top.sv
